// ===== rtl/core/bffa_pkg.sv =====
// bffa_pkg: sizes, item codes, memory port structs and bit-search helpers
// for the first-fit block allocator. No dependencies; used by
// bffa_map_mem and bitmap_first_fit_block_allocator.
package bffa_pkg;

   localparam int NUM_BLOCKS    = 4096;
   localparam int BLOCK_W       = 16;
   localparam int INDEX_W       = 12;
   localparam int MAP_WORDS     = (NUM_BLOCKS + 7) / 8;
   localparam int GROUP_SLOTS   = 32;
   localparam int SLOT_W        = 5;
   localparam int NUM_GROUPS    = (MAP_WORDS + GROUP_SLOTS - 1) / GROUP_SLOTS;
   localparam int GROUP_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int NUM_GROUPS_P2 = 1 << GROUP_W;
   localparam int ADDR_W        = GROUP_W + SLOT_W;
   localparam int MAP_DEPTH     = 1 << ADDR_W;
   localparam int IDX_W         = ADDR_W + 3;

   localparam logic [7:0] ALL_FREE_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      KIND_REBUILD  = 2'd0,
      KIND_MARK     = 2'd1,
      KIND_ALLOC    = 2'd2,
      KIND_MARK_ALL = 2'd3
   } kind_type;

   typedef struct packed {
      logic                   map_re;
      logic [ADDR_W-1:0]      map_raddr;
      logic                   map_we;
      logic [ADDR_W-1:0]      map_waddr;
      logic [7:0]             map_wdata;
      logic                   sum_re;
      logic [GROUP_W-1:0]     sum_raddr;
      logic                   sum_we;
      logic [GROUP_W-1:0]     sum_waddr;
      logic [GROUP_SLOTS-1:0] sum_wdata;
   } mem_req_type;

   typedef struct packed {
      logic [7:0]             map_rdata;
      logic [GROUP_SLOTS-1:0] sum_rdata;
   } mem_rsp_type;

   // free pattern of one map word right after a rebuild
   function automatic logic [7:0] rebuild_word(input logic [ADDR_W-1:0] addr);
      logic [7:0]       w;
      logic [IDX_W-1:0] blk;
      w = ALL_FREE_BYTE;
      for (int b = 0; b < 8; b++) begin
         blk = {addr, 3'(b)};
         if (32'(blk) >= 32'(NUM_BLOCKS) || blk == '0) begin
            w[b] = 1'b0;
         end
      end
      return w;
   endfunction

   function automatic logic [2:0] lowest_bit(input logic [7:0] v);
      logic [2:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] lowest_slot(input logic [GROUP_SLOTS-1:0] v);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = SLOT_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [GROUP_W-1:0] lowest_group(input logic [NUM_GROUPS_P2-1:0] v);
      logic [GROUP_W-1:0] r;
      r = '0;
      for (int i = NUM_GROUPS_P2 - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = GROUP_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/bffa_map_mem.sv =====
// bffa_map_mem: free map memory (one byte per 8 blocks) and the per-group
// nonzero summary memory, both with registered reads.
// Depends on bffa_pkg.
module bffa_map_mem (
   input  logic                 clock,
   input  bffa_pkg::mem_req_type mem_req,
   output bffa_pkg::mem_rsp_type mem_rsp
);

   logic [7:0]                       map_mem [bffa_pkg::MAP_DEPTH];
   logic [bffa_pkg::GROUP_SLOTS-1:0] sum_mem [bffa_pkg::NUM_GROUPS_P2];
   logic [7:0]                       map_rdata_ff;
   logic [bffa_pkg::GROUP_SLOTS-1:0] sum_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.map_we) begin
         map_mem[mem_req.map_waddr] <= mem_req.map_wdata;
      end
      // read data holds while no read is issued
      if (mem_req.map_re) begin
         map_rdata_ff <= map_mem[mem_req.map_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.sum_we) begin
         sum_mem[mem_req.sum_waddr] <= mem_req.sum_wdata;
      end
      if (mem_req.sum_re) begin
         sum_rdata_ff <= sum_mem[mem_req.sum_raddr];
      end
   end

   assign mem_rsp.map_rdata = map_rdata_ff;
   assign mem_rsp.sum_rdata = sum_rdata_ff;

endmodule

// ===== rtl/core/bitmap_first_fit_block_allocator.sv =====
// bitmap_first_fit_block_allocator: first-fit free block allocator over a
// one-bit-per-block free map. Depends on bffa_pkg and bffa_map_mem.
//
//  channel | ports                               | beat
//  req     | req_valid req_stall req_kind req_block | one map command
//  rsp     | rsp_valid rsp_stall rsp_alloc_index rsp_full_res | allocate result
//
// mark used reads the map and summary words, then writes both back; mark all
// used and an ignored mark are done in the idle state. allocate steps through
// group flag pick with summary read, map read and write back, and answers from
// the flag pick when the map is full. rebuild sweeps all MAP_DEPTH map words,
// one word a cycle. reset clears the group flags, so the map reads as all in
// use at once. an allocate waits in place while the result is stalled.
module bitmap_first_fit_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [bffa_pkg::BLOCK_W-1:0] req_block,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bffa_pkg::INDEX_W-1:0] rsp_alloc_index,
   output logic                        rsp_full_res
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_MARK_RD,
      S_FIND,
      S_SLOT,
      S_MOD
   } state_type;

   localparam int AW = bffa_pkg::ADDR_W;
   localparam int SW = bffa_pkg::SLOT_W;

   state_type                             state_ff, state_in;
   logic [bffa_pkg::NUM_GROUPS_P2-1:0]    flags_ff, flags_in;
   logic [AW-1:0]                         word_ff, word_in;
   logic [2:0]                            bit_ff, bit_in;
   logic                                  is_alloc_ff, is_alloc_in;
   logic [AW-1:0]                         sweep_ff, sweep_in;
   logic [bffa_pkg::GROUP_SLOTS-1:0]      acc_ff, acc_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [bffa_pkg::INDEX_W-1:0]          index_ff, index_in;
   logic                                  full_ff, full_in;

   bffa_pkg::mem_req_type                 mem_req;
   bffa_pkg::mem_rsp_type                 mem_rsp;
   logic                                  can_emit;

   bffa_map_mem u_map_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      logic [7:0]                       pat;
      logic [bffa_pkg::GROUP_SLOTS-1:0] acc_cur;
      logic [bffa_pkg::GROUP_W-1:0]     grp;
      logic [SW-1:0]                    slot;
      logic [2:0]                       mod_bit;
      logic [7:0]                       mod_word;
      logic [bffa_pkg::GROUP_SLOTS-1:0] mod_sum;

      state_in     = state_ff;
      flags_in     = flags_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      is_alloc_in  = is_alloc_ff;
      sweep_in     = sweep_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      index_in     = index_ff;
      full_in      = full_ff;
      mem_req      = '0;

      pat      = bffa_pkg::rebuild_word(sweep_ff);
      acc_cur  = ((sweep_ff[SW-1:0] == '0) ? '0 : acc_ff)
               | (bffa_pkg::GROUP_SLOTS'(pat != '0) << sweep_ff[SW-1:0]);
      grp      = word_ff[AW-1:SW];
      slot     = bffa_pkg::lowest_slot(mem_rsp.sum_rdata);
      mod_bit  = is_alloc_ff ? bffa_pkg::lowest_bit(mem_rsp.map_rdata) : bit_ff;
      mod_word = mem_rsp.map_rdata & ~(8'b1 << mod_bit);
      mod_sum  = (mod_word == '0)
               ? (mem_rsp.sum_rdata & ~(bffa_pkg::GROUP_SLOTS'(1) << word_ff[SW-1:0]))
               : mem_rsp.sum_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (bffa_pkg::kind_type'(req_kind))
                  bffa_pkg::KIND_REBUILD: begin
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  bffa_pkg::KIND_MARK: begin
                     // numbers beyond the map are dropped here
                     if (32'(req_block) < 32'(bffa_pkg::NUM_BLOCKS)) begin
                        word_in     = req_block[bffa_pkg::IDX_W-1:3];
                        bit_in      = req_block[2:0];
                        is_alloc_in = 1'b0;
                        state_in    = S_MARK_RD;
                     end
                  end
                  bffa_pkg::KIND_ALLOC: begin
                     is_alloc_in = 1'b1;
                     state_in    = S_FIND;
                  end
                  bffa_pkg::KIND_MARK_ALL: begin
                     // no flag set means no group is searched until a rebuild
                     flags_in = '0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            mem_req.map_we    = 1'b1;
            mem_req.map_waddr = sweep_ff;
            mem_req.map_wdata = pat;
            acc_in            = acc_cur;
            if (sweep_ff[SW-1:0] == '1) begin
               mem_req.sum_we    = 1'b1;
               mem_req.sum_waddr = sweep_ff[AW-1:SW];
               mem_req.sum_wdata = acc_cur;
               flags_in[sweep_ff[AW-1:SW]] = (acc_cur != '0);
            end
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_MARK_RD: begin
            mem_req.map_re    = 1'b1;
            mem_req.map_raddr = word_ff;
            mem_req.sum_re    = 1'b1;
            mem_req.sum_raddr = grp;
            state_in          = S_MOD;
         end
         S_FIND: begin
            if (flags_ff == '0) begin
               if (can_emit) begin
                  rsp_valid_in = 1'b1;
                  index_in     = '0;
                  full_in      = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               mem_req.sum_re    = 1'b1;
               mem_req.sum_raddr = bffa_pkg::lowest_group(flags_ff);
               word_in           = {bffa_pkg::lowest_group(flags_ff), SW'(0)};
               state_in          = S_SLOT;
            end
         end
         S_SLOT: begin
            mem_req.map_re    = 1'b1;
            mem_req.map_raddr = {grp, slot};
            word_in           = {grp, slot};
            state_in          = S_MOD;
         end
         S_MOD: begin
            if (!is_alloc_ff || can_emit) begin
               mem_req.map_we    = 1'b1;
               mem_req.map_waddr = word_ff;
               mem_req.map_wdata = mod_word;
               mem_req.sum_we    = 1'b1;
               mem_req.sum_waddr = grp;
               mem_req.sum_wdata = mod_sum;
               // a mark on an unflagged group never raises its flag
               flags_in[grp] = flags_ff[grp] && (mod_sum != '0);
               if (is_alloc_ff) begin
                  rsp_valid_in = 1'b1;
                  index_in     = bffa_pkg::INDEX_W'({word_ff, mod_bit});
                  full_in      = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      bit_ff      <= bit_in;
      is_alloc_ff <= is_alloc_in;
      sweep_ff    <= sweep_in;
      acc_ff      <= acc_in;
      index_ff    <= index_in;
      full_ff     <= full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_index = index_ff;
   assign rsp_full_res    = full_ff;

   // a flagged group always has a nonzero summary word
   a_summary_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SLOT |-> mem_rsp.sum_rdata != '0)
      else $error("summary word of a flagged group is zero");

   // the summary slot picked always points at a word with a free bit
   a_word_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD && is_alloc_ff) |-> mem_rsp.map_rdata != '0)
      else $error("allocate picked a map word with no free bit");

   // a new result only comes out of the search or the write back
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall))
         |-> $past(state_ff == S_FIND || state_ff == S_MOD))
      else $error("result raised outside an allocate");

   // a full result carries index zero
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && full_ff) |-> index_ff == '0)
      else $error("full result with nonzero index");

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for bitmap_first_fit_block_allocator. A clocked
// driver feeds map commands from a queue, a clocked monitor checks allocate
// results against a bit-level free map kept here. Depends on bffa_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT    = 800000;
   localparam int QUIET_FROM   = 4000;
   localparam int QUIET_TO     = 10000;
   localparam int DRAIN_ALLOCS = 1000;
   localparam int MIXED_ITEMS  = 800;
   localparam int TAIL_CYCLES  = 600;

   typedef struct {
      bffa_pkg::kind_type           kind;
      logic [bffa_pkg::BLOCK_W-1:0] block;
      bit                           hold;
   } map_cmd_type;

   typedef struct {
      logic [bffa_pkg::INDEX_W-1:0] index;
      logic                         full;
   } alloc_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_kind = '0;
   logic [bffa_pkg::BLOCK_W-1:0] req_block = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [bffa_pkg::INDEX_W-1:0] rsp_alloc_index;
   logic                         rsp_full_res;

   map_cmd_type                   cmd_fifo[$];
   alloc_result_type              alloc_due[$];
   bit [bffa_pkg::NUM_BLOCKS-1:0] free_bits;

   int cycle_count       = 0;
   int cmds_queued       = 0;
   int cmds_taken        = 0;
   int results_predicted = 0;
   int results_checked   = 0;
   int mismatches        = 0;
   int grants            = 0;
   int full_seen         = 0;
   int top_index         = 0;
   int kind_count[4]     = '{default: 0};

   map_cmd_type      next_cmd;
   alloc_result_type want;
   logic             quiet;
   logic             hold_ok;

   assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   bitmap_first_fit_block_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_block       (req_block),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_full_res    (rsp_full_res)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic push_cmd(input bffa_pkg::kind_type k,
                           input logic [bffa_pkg::BLOCK_W-1:0] b, input bit hold);
      map_cmd_type c;
      c.kind  = k;
      c.block = b;
      c.hold  = hold;
      cmd_fifo.push_back(c);
      cmds_queued++;
   endtask

   // update the free map for one accepted beat, queue the allocate answer
   task automatic apply_command(input bffa_pkg::kind_type k,
                                input logic [bffa_pkg::BLOCK_W-1:0] blk);
      alloc_result_type res;
      int               hit;
      hit = -1;
      kind_count[k]++;
      case (k)
         bffa_pkg::KIND_REBUILD: begin
            free_bits    = '1;
            free_bits[0] = 1'b0;
         end
         bffa_pkg::KIND_MARK: begin
            if (int'(blk) < bffa_pkg::NUM_BLOCKS) begin
               free_bits[blk[bffa_pkg::IDX_W-1:0]] = 1'b0;
            end
         end
         bffa_pkg::KIND_MARK_ALL: begin
            free_bits = '0;
         end
         default: begin
            // coarse scan by 32-bit chunks, then the first set bit inside
            for (int w = 0; w < bffa_pkg::NUM_BLOCKS && hit < 0; w += 32) begin
               if (free_bits[w +: 32] != '0) begin
                  for (int b = w; b < w + 32 && b < bffa_pkg::NUM_BLOCKS && hit < 0; b++) begin
                     if (free_bits[b]) begin
                        hit = b;
                     end
                  end
               end
            end
            if (hit >= 0) begin
               free_bits[hit] = 1'b0;
               res.index      = bffa_pkg::INDEX_W'(hit);
               res.full       = 1'b0;
            end else begin
               res.index = '0;
               res.full  = 1'b1;
            end
            alloc_due.push_back(res);
            results_predicted++;
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(bffa_pkg::kind_type'(req_kind), req_block);
            cmds_taken++;
         end
         if (!(req_valid && req_stall)) begin
            hold_ok = (cmd_fifo.size() != 0) &&
                      (!cmd_fifo[0].hold || results_predicted == results_checked);
            if (hold_ok && (quiet || $urandom_range(99) >= 32)) begin
               next_cmd = cmd_fifo.pop_front();
               req_valid <= 1'b1;
               req_kind  <= next_cmd.kind;
               req_block <= next_cmd.block;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 32);
         if (rsp_valid && !rsp_stall) begin
            if (alloc_due.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing pending: index %0d full %0b",
                                         rsp_alloc_index, rsp_full_res));
            end else begin
               want = alloc_due.pop_front();
               results_checked <= results_checked + 1;
               if (rsp_alloc_index !== want.index) begin
                  report_mismatch($sformatf("alloc_index %0d, predicted %0d",
                                            rsp_alloc_index, want.index));
               end
               if (rsp_full_res !== want.full) begin
                  report_mismatch($sformatf("full_res %0b, predicted %0b",
                                            rsp_full_res, want.full));
               end
               if (want.full) begin
                  full_seen++;
               end else begin
                  grants++;
                  if (int'(want.index) > top_index) begin
                     top_index = int'(want.index);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Run limit of %0d cycles reached", RUN_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int                           pick;
      int                           seg_len;
      int                           mixed;
      logic [bffa_pkg::BLOCK_W-1:0] blk;
      mixed = 0;

      // directed: map all in use after reset, holes, out-of-range marks, full map
      push_cmd(bffa_pkg::KIND_ALLOC,    16'h0000, 1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'd5,    1'b0);
      push_cmd(bffa_pkg::KIND_REBUILD,  16'hFFFF, 1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'hFFFF, 1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'h0000, 1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'd3,    1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'(bffa_pkg::NUM_BLOCKS), 1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'hFFFF, 1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'd0,    1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'h5A5A, 1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'(bffa_pkg::NUM_BLOCKS - 1), 1'b0);
      push_cmd(bffa_pkg::KIND_MARK_ALL, 16'hA5A5, 1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'h0000, 1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'hFFFF, 1'b0);
      push_cmd(bffa_pkg::KIND_REBUILD,  16'h0000, 1'b1);
      push_cmd(bffa_pkg::KIND_MARK,     16'd1,    1'b0);
      push_cmd(bffa_pkg::KIND_MARK,     16'd2,    1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'h1234, 1'b0);
      push_cmd(bffa_pkg::KIND_ALLOC,    16'h0000, 1'b1);

      // long allocate run from a fresh map so the index climbs well up
      push_cmd(bffa_pkg::KIND_REBUILD, bffa_pkg::BLOCK_W'($urandom), 1'b0);
      for (int i = 0; i < DRAIN_ALLOCS; i++) begin
         if ($urandom_range(9) == 0) begin
            push_cmd(bffa_pkg::KIND_MARK,
                     bffa_pkg::BLOCK_W'($urandom_range(bffa_pkg::NUM_BLOCKS - 1)), 1'b0);
         end
         push_cmd(bffa_pkg::KIND_ALLOC, bffa_pkg::BLOCK_W'($urandom), i == DRAIN_ALLOCS / 2);
      end

      // short sessions: rebuild or mark all, marks and allocates, some noise
      while (mixed < MIXED_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            push_cmd(bffa_pkg::KIND_REBUILD, bffa_pkg::BLOCK_W'($urandom), 1'b0);
         end else if (pick < 80) begin
            push_cmd(bffa_pkg::KIND_MARK_ALL, bffa_pkg::BLOCK_W'($urandom), 1'b0);
         end
         seg_len = $urandom_range(60, 10);
         for (int i = 0; i < seg_len; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: blk = bffa_pkg::BLOCK_W'($urandom_range(63));
                  4, 5, 6, 7: blk = bffa_pkg::BLOCK_W'($urandom_range(bffa_pkg::NUM_BLOCKS - 1));
                  default:    blk = bffa_pkg::BLOCK_W'($urandom);
               endcase
               push_cmd(bffa_pkg::KIND_MARK, blk, $urandom_range(99) == 0);
            end else if (pick < 92) begin
               push_cmd(bffa_pkg::KIND_ALLOC, bffa_pkg::BLOCK_W'($urandom),
                        $urandom_range(99) == 0);
            end else begin
               push_cmd(bffa_pkg::kind_type'($urandom_range(3)),
                        bffa_pkg::BLOCK_W'($urandom), 1'b0);
            end
         end
         mixed += seg_len;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cmds_taken != cmds_queued) @(posedge clock);
      while (alloc_due.size() != 0) @(posedge clock);
      // a rebuild can still be sweeping the map
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d beats: %0d rebuild, %0d mark, %0d allocate, %0d mark-all",
               cmds_taken, kind_count[bffa_pkg::KIND_REBUILD], kind_count[bffa_pkg::KIND_MARK],
               kind_count[bffa_pkg::KIND_ALLOC], kind_count[bffa_pkg::KIND_MARK_ALL]);
      $display("Allocates granted %0d blocks (highest index %0d), %0d hit a full map",
               grants, top_index, full_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
